### rtl/ort_pkg.sv
// Shared types and constants of the outstanding request tracker.
`timescale 1ns / 1ps
package ort_pkg;

	localparam int unsigned ID_W   = 64;
	localparam int unsigned GEN_W  = 16;
	localparam int unsigned TMO_W  = 16;
	localparam int unsigned CODE_W = 8;
	localparam int unsigned TIME_W = 32;

	localparam logic [2:0] MODE_BEGIN    = 3'd0;
	localparam logic [2:0] MODE_COMPLETE = 3'd1;
	localparam logic [2:0] MODE_FAIL     = 3'd2;
	localparam logic [2:0] MODE_FAIL_GEN = 3'd3;
	localparam logic [2:0] MODE_TICK     = 3'd4;
	localparam logic [2:0] MODE_REJECT   = 3'd5;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND   = 3'd1;
	localparam logic [2:0] ST_FAILED      = 3'd2;
	localparam logic [2:0] ST_TIMEOUT     = 3'd3;
	localparam logic [2:0] ST_UNAVAILABLE = 3'd4;
	localparam logic [2:0] ST_FULL        = 3'd5;

	typedef struct packed {
		logic [2:0]        mode;
		logic [ID_W-1:0]   req_id;
		logic [GEN_W-1:0]  generation;
		logic [TMO_W-1:0]  ttl_ms;
		logic [CODE_W-1:0] fail_code;
	} in_item_t;

	typedef struct packed {
		logic [ID_W-1:0]   req_id_res;
		logic [2:0]        status;
		logic [CODE_W-1:0] fail_code_res;
		logic              last;
		logic              any_pending;
	} out_item_t;

	// Token that walks the cell chain: one slot visit per cell per cycle.
	typedef struct packed {
		logic              act;      // operation in flight
		logic [2:0]        mode;
		logic [ID_W-1:0]   key_id;   // search key, or the id given by begin
		logic [GEN_W-1:0]  gen;
		logic [TIME_W-1:0] deadline;
		logic              done;     // begin placed or single removal found
	} tok_t;

	// Per-cell report of what happened at that slot.
	typedef struct packed {
		logic            hit;
		logic [ID_W-1:0] id;
	} cell_rpt_t;

endpackage

### rtl/ort_if.sv
// Valid/ready channel interface used by the tracker.
`timescale 1ns / 1ps
interface ort_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/ort_cell.sv
// One table slot: holds an entry and acts on the token passing through it.
`timescale 1ns / 1ps
module ort_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                visit,
	input  logic                clear,
	input  logic [ort_pkg::TIME_W-1:0] now,
	input  ort_pkg::tok_t       tok_in,
	output ort_pkg::tok_t       tok_out,
	output ort_pkg::cell_rpt_t  rpt,
	output logic                valid
);
	logic                         valid_q;
	logic [ort_pkg::ID_W-1:0]     id_q;
	logic [ort_pkg::GEN_W-1:0]    gen_q;
	logic [ort_pkg::TIME_W-1:0]   dl_q;
	logic [ort_pkg::TIME_W-1:0]   diff;
	logic                         take, drop;

	assign diff = now - dl_q;

	always_comb begin
		take = 1'b0;
		drop = 1'b0;
		tok_out = tok_in;
		if (visit && tok_in.act) begin
			case (tok_in.mode)
				ort_pkg::MODE_BEGIN: take = !valid_q && !tok_in.done;
				ort_pkg::MODE_COMPLETE, ort_pkg::MODE_FAIL:
					drop = valid_q && !tok_in.done && (id_q == tok_in.key_id);
				ort_pkg::MODE_FAIL_GEN: drop = valid_q && (gen_q == tok_in.gen);
				ort_pkg::MODE_TICK: drop = valid_q && !diff[ort_pkg::TIME_W-1];
				ort_pkg::MODE_REJECT: drop = valid_q;
				default: ;
			endcase
		end
		if (take || (drop && (tok_in.mode == ort_pkg::MODE_COMPLETE ||
				tok_in.mode == ort_pkg::MODE_FAIL)))
			tok_out.done = 1'b1;
	end

	assign rpt.hit = drop;
	assign rpt.id  = id_q;
	assign valid   = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clear) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end else if (drop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			id_q  <= tok_in.key_id;
			gen_q <= tok_in.gen;
			dl_q  <= tok_in.deadline;
		end
	end
endmodule

### rtl/outstanding_request_tracker_core.sv
// Top level of the outstanding request tracker: cell chain and sequencer.
// Usage:
//   in  (sink)   one transaction per operation: mode, req_id, generation,
//                ttl_ms, fail_code. mode 0 begin, 1 complete, 2 fail,
//                3 fail generation, 4 tick, 5 reject all; 6 and 7 ignored.
//   out (source) zero or more result transactions per operation, in slot
//                order; the final one carries last.
// Operation: the accepted transaction becomes a token that walks the chain
// of SLOTS cells, one cell per cycle. Each cell that removes its entry
// reports a hit, held in a per-cell pending bit. Begin, complete and fail
// then load their one result into the output register once it is free.
// Scans drain one slot per cycle while the output register is free, from
// slot 0 up to the highest removed slot; a scan that removes nothing
// gives no result. in.ready rises once the operation has ended and the
// sequencer is back in idle. A stalled receiver holds the output register;
// the drain or the single result then waits until it is free, while a new
// transaction may still be accepted behind the waiting result.
// Results carry any_pending as seen once the walk has finished.
// Reset clears all slot valid bits, sets next_id to one and the clock to 0;
// slot contents are written only by begin.
`timescale 1ns / 1ps
module outstanding_request_tracker_core #(
	parameter int unsigned SLOTS = 16
) (
	input  logic clk,
	input  logic arst_n,
	ort_if.sink  in,
	ort_if.source out
);
	localparam int unsigned PW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned CW = $clog2(SLOTS + 1);

	typedef enum logic [1:0] {S_IDLE, S_WALK, S_DRAIN, S_SINGLE} state_t;

	state_t                        state_q;
	ort_pkg::in_item_t             item_q;
	ort_pkg::tok_t                 tok_q;
	logic [CW-1:0]                 pos_q;
	logic [ort_pkg::ID_W-1:0]      next_id_q;
	logic [ort_pkg::TIME_W-1:0]    now_q;
	logic [SLOTS-1:0]              hit_q;
	logic [ort_pkg::ID_W-1:0]      hid_q [SLOTS];
	logic [PW-1:0]                 dpos_q;
	logic                          out_valid_q;
	ort_pkg::out_item_t            out_q;

	ort_pkg::tok_t                 chain [SLOTS];
	ort_pkg::cell_rpt_t            rpt [SLOTS];
	logic [SLOTS-1:0]              vld;
	logic                          out_free;
	logic                          any;
	logic                          more;
	logic                          load;
	ort_pkg::out_item_t            res_d;

	// The token is fed to all cells from the register; only the visited
	// cell acts, and its output token is registered back.
	genvar g;
	generate
		for (g = 0; g < SLOTS; g++) begin : g_cell
			ort_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.visit  (state_q == S_WALK && pos_q == CW'(g)),
				.clear  (1'b0),
				.now    (now_q),
				.tok_in (tok_q),
				.tok_out(chain[g]),
				.rpt    (rpt[g]),
				.valid  (vld[g])
			);
		end
	endgenerate

	assign any      = |vld;
	assign out_free = !out_valid_q || out.ready;
	assign in.ready = (state_q == S_IDLE);
	assign out.valid = out_valid_q;
	assign out.data  = out_q;
	// Another hit waits beyond the current drain position.
	always_comb begin
		more = 1'b0;
		for (int k = 0; k < SLOTS; k++)
			if (k > int'(dpos_q) && hit_q[k]) more = 1'b1;
	end

	// Build the next result and decide whether to load the output register.
	always_comb begin
		load                = 1'b0;
		res_d.req_id_res    = item_q.req_id;
		res_d.status        = ort_pkg::ST_OK;
		res_d.fail_code_res = '0;
		res_d.last          = 1'b1;
		res_d.any_pending   = any;
		case (state_q)
			S_SINGLE: begin
				load = out_free;
				if (item_q.mode == ort_pkg::MODE_BEGIN) begin
					if (tok_q.done) begin
						res_d.req_id_res = next_id_q;
					end else begin
						res_d.status     = ort_pkg::ST_FULL;
						res_d.req_id_res = '0;
					end
				end else if (!tok_q.done) begin
					res_d.status = ort_pkg::ST_NOT_FOUND;
				end else if (item_q.mode == ort_pkg::MODE_FAIL) begin
					res_d.status        = ort_pkg::ST_FAILED;
					res_d.fail_code_res = item_q.fail_code;
				end
			end
			S_DRAIN: begin
				load             = out_free && hit_q[dpos_q];
				res_d.req_id_res = hid_q[dpos_q];
				res_d.last       = !more;
				case (item_q.mode)
					ort_pkg::MODE_FAIL_GEN: begin
						res_d.status        = ort_pkg::ST_FAILED;
						res_d.fail_code_res = item_q.fail_code;
					end
					ort_pkg::MODE_TICK: res_d.status = ort_pkg::ST_TIMEOUT;
					default: res_d.status = ort_pkg::ST_UNAVAILABLE;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tok_q.act   <= 1'b0;
			pos_q       <= '0;
			next_id_q   <= ort_pkg::ID_W'(1);
			now_q       <= '0;
			hit_q       <= '0;
			dpos_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// hold a result until taken; load the next one when free
			out_valid_q <= load || (out_valid_q && !out.ready);
			if (load) out_q <= res_d;
			case (state_q)
				S_IDLE: begin
					if (in.valid && in.ready) begin
						item_q         <= in.data;
						tok_q.act      <= 1'b1;
						tok_q.mode     <= in.data.mode;
						tok_q.key_id   <= (in.data.mode == ort_pkg::MODE_BEGIN) ?
							next_id_q : in.data.req_id;
						tok_q.gen      <= in.data.generation;
						tok_q.deadline <= (in.data.mode == ort_pkg::MODE_TICK) ?
							now_q + 1'b1 :
							now_q + ort_pkg::TIME_W'(in.data.ttl_ms);
						tok_q.done     <= 1'b0;
						if (in.data.mode == ort_pkg::MODE_TICK) now_q <= now_q + 1'b1;
						pos_q          <= '0;
						hit_q          <= '0;
						state_q        <= S_WALK;
					end
				end
				S_WALK: begin
					// advance one cell; record removals
					tok_q <= chain[pos_q[PW-1:0]];
					hit_q[pos_q[PW-1:0]] <= rpt[pos_q[PW-1:0]].hit;
					hid_q[pos_q[PW-1:0]] <= rpt[pos_q[PW-1:0]].id;
					if (pos_q == CW'(SLOTS - 1)) begin
						pos_q <= '0;
						if (item_q.mode == ort_pkg::MODE_BEGIN ||
								item_q.mode == ort_pkg::MODE_COMPLETE ||
								item_q.mode == ort_pkg::MODE_FAIL)
							state_q <= S_SINGLE;
						else if (item_q.mode == ort_pkg::MODE_FAIL_GEN ||
								item_q.mode == ort_pkg::MODE_TICK ||
								item_q.mode == ort_pkg::MODE_REJECT) begin
							dpos_q  <= '0;
							state_q <= S_DRAIN;
						end else
							state_q <= S_IDLE;
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end
				S_SINGLE: begin
					if (out_free) begin
						if (item_q.mode == ort_pkg::MODE_BEGIN && tok_q.done)
							next_id_q <= next_id_q + 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_DRAIN: begin
					// walk pending hits in slot order, one slot per cycle while the output is free
					if (out_free) begin
						if (!more || dpos_q == PW'(SLOTS - 1)) begin
							state_q <= S_IDLE;
						end else begin
							dpos_q <= dpos_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
